/* rtl/kslpc_pkg.sv */
// Package for the key short/long press classifier.
// Phase encoding, event codes, register indexes and reset values; no dependencies.
`default_nettype none

package kslpc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned EventW   = 2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CHECK1    = 3'd1,
    PH_CHECK2    = 3'd2,
    PH_HOLD      = 3'd3,
    PH_REL_SHORT = 3'd4,
    PH_SET_SHORT = 3'd5,
    PH_REL_LONG  = 3'd6,
    PH_SET_LONG  = 3'd7
  } phase_t;

  typedef logic [EventW-1:0] event_code_t;

  localparam event_code_t EV_NONE  = 2'd0;
  localparam event_code_t EV_SHORT = 2'd1;
  localparam event_code_t EV_LONG  = 2'd2;
  localparam event_code_t EV_BAD   = 2'd3;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LONG_MODE      = 3'd0;
  localparam cfg_idx_t REG_POLL_PERIOD    = 3'd1;
  localparam cfg_idx_t REG_FIRST_CHECK    = 3'd2;
  localparam cfg_idx_t REG_SECOND_CHECK   = 3'd3;
  localparam cfg_idx_t REG_LONG_LIMIT     = 3'd4;
  localparam cfg_idx_t REG_RELEASE_SETTLE = 3'd5;

  localparam logic [7:0] RST_POLL_PERIOD    = 8'd10;
  localparam logic [7:0] RST_FIRST_CHECK    = 8'd5;
  localparam logic [7:0] RST_SECOND_CHECK   = 8'd15;
  localparam logic [7:0] RST_LONG_LIMIT     = 8'd100;
  localparam logic [7:0] RST_RELEASE_SETTLE = 8'd60;

endpackage

`default_nettype wire

/* rtl/key_short_long_press_classifier.sv */
// Top level of the key short/long press classifier.
// Depends on kslpc_pkg for phase, event and register codes.
`default_nettype none

// One input word is one millisecond tick carrying the sampled key level, and
// every accepted word yields exactly one result word (press_event: 0 none,
// 1 short, 2 long), held in the result register, or in the skid entry while
// the output stalls. The whole per-tick state update sits between the phase/
// counter registers and the result register, so a word can be accepted every
// clock while in_stall is low. The result side has a two-entry buffer (result
// register plus a skid entry); in_stall rises only when both are full.
// Configuration registers are written directly through cfg_we/cfg_index/
// cfg_data; indexes beyond the register list are ignored. Delays and the
// long limit read as 1 when set to 0.
module key_short_long_press_classifier (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // tick channel
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         key_pressed,
  // event channel
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [kslpc_pkg::EventW-1:0] press_event,
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire kslpc_pkg::cfg_idx_t          cfg_index,
  input  wire logic [kslpc_pkg::CfgDataW-1:0] cfg_data
);
  import kslpc_pkg::*;

  // configuration registers
  logic       long_mode;
  logic [7:0] poll_period;
  logic [7:0] first_check_delay;
  logic [7:0] second_check_delay;
  logic [7:0] long_count_limit;
  logic [7:0] release_settle;

  // tracking state
  phase_t     phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] hold_count, hold_count_next;
  logic       long_seen, long_seen_next;

  // output buffer
  logic        skid_valid;
  event_code_t skid_event;
  event_code_t ev;

  logic       in_fire;
  logic       out_free;
  logic [7:0] cnt_inc;
  logic [7:0] delay_sel;
  logic       due;
  logic [7:0] hold_inc;
  logic       long_hit;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_mode          <= 1'b0;
      poll_period        <= RST_POLL_PERIOD;
      first_check_delay  <= RST_FIRST_CHECK;
      second_check_delay <= RST_SECOND_CHECK;
      long_count_limit   <= RST_LONG_LIMIT;
      release_settle     <= RST_RELEASE_SETTLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_MODE:      long_mode          <= cfg_data[0];
        REG_POLL_PERIOD:    poll_period        <= cfg_data;
        REG_FIRST_CHECK:    first_check_delay  <= cfg_data;
        REG_SECOND_CHECK:   second_check_delay <= cfg_data;
        REG_LONG_LIMIT:     long_count_limit   <= cfg_data;
        REG_RELEASE_SETTLE: release_settle     <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase timer: counts up, fires when it reaches the phase's delay
  always_comb begin
    case (phase)
      PH_CHECK1:                 delay_sel = first_check_delay;
      PH_CHECK2:                 delay_sel = second_check_delay;
      PH_SET_SHORT, PH_SET_LONG: delay_sel = release_settle;
      default:                   delay_sel = poll_period;
    endcase
  end

  assign cnt_inc  = tick_count + 8'd1;
  assign due      = (cnt_inc >= delay_sel);
  // hold periods saturate at all ones
  assign hold_inc = (hold_count != 8'hFF) ? hold_count + 8'd1 : hold_count;
  assign long_hit = long_seen || (hold_inc >= long_count_limit);

  always_comb begin
    phase_next      = phase;
    tick_count_next = due ? 8'd0 : cnt_inc;
    hold_count_next = hold_count;
    long_seen_next  = long_seen;
    ev              = EV_NONE;
    case (phase)
      PH_IDLE: begin
        if (due && key_pressed) phase_next = PH_CHECK1;
      end
      PH_CHECK1: begin
        if (due) phase_next = key_pressed ? PH_CHECK2 : PH_IDLE;
      end
      PH_CHECK2: begin
        if (due) begin
          if (!key_pressed) begin
            phase_next = PH_IDLE;
          end else if (!long_mode) begin
            ev         = EV_SHORT;
            phase_next = PH_REL_SHORT;
          end else begin
            hold_count_next = 8'd0;
            long_seen_next  = 1'b0;
            phase_next      = PH_HOLD;
          end
        end
      end
      PH_HOLD: begin
        if (due) begin
          hold_count_next = hold_inc;
          long_seen_next  = long_hit;
          // release while holding reports at once, no settle wait
          if (!key_pressed) begin
            ev         = long_hit ? EV_LONG : EV_SHORT;
            phase_next = PH_IDLE;
          end else if (long_hit) begin
            phase_next = PH_REL_LONG;
          end
        end
      end
      PH_REL_SHORT: begin
        if (due && !key_pressed) phase_next = PH_SET_SHORT;
      end
      PH_SET_SHORT: begin
        if (due) phase_next = key_pressed ? PH_REL_SHORT : PH_IDLE;
      end
      PH_REL_LONG: begin
        if (due && !key_pressed) phase_next = PH_SET_LONG;
      end
      PH_SET_LONG: begin
        if (due) begin
          if (key_pressed) begin
            phase_next = PH_REL_LONG;
          end else begin
            ev         = long_seen ? EV_LONG : EV_SHORT;
            phase_next = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 8'd0;
      hold_count <= 8'd0;
      long_seen  <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      hold_count <= hold_count_next;
      long_seen  <= long_seen_next;
    end
  end

  // result register, skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      press_event <= skid_valid ? skid_event : ev;
    end else if (in_fire) begin
      skid_event <= ev;
    end
  end

endmodule

`default_nettype wire

/* rtl/kslpc_checker.sv */
// Port-level checks for the key short/long press classifier, bound to the top.
// Depends on kslpc_pkg for event codes.
`default_nettype none

module kslpc_port_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [kslpc_pkg::EventW-1:0] press_event
);
  import kslpc_pkg::*;

  // event code 3 is never produced
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> press_event != EV_BAD)
    else $error("undefined press event code");

  // skid entry fills only behind a full result register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // an accepted tick is always followed by out_valid in the next cycle
  a_tick_gives_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(press_event)))
    else $error("stalled result changed");

  // reset empties the output buffer
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output buffer not cleared by reset");

endmodule

bind key_short_long_press_classifier kslpc_port_checker u_kslpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .press_event (press_event)
);

`default_nettype wire
